@@ rtl/eihp_pkg.sv @@
// shared types and constants for the ethernet / ipv4 / l4 header parser
package eihp_pkg;

    // default width of the frame byte counter
    localparam int COUNT_BITS_DEF = 16;

    // byte positions in the frame; TCP_OFF_POS counts from the start of the transport header
    localparam int TYPE_POS_HI  = 12;
    localparam int TYPE_POS_LO  = 13;
    localparam int IHL_POS      = 14;
    localparam int PROTO_POS    = 23;
    localparam int SRC_FIRST    = 26;
    localparam int SRC_LAST     = 29;
    localparam int DST_FIRST    = 30;
    localparam int DST_LAST     = 33;
    localparam int TCP_OFF_POS  = 12;

    // header lengths in bytes
    localparam int ETH_LEN      = 14;
    localparam int IP_MIN_LEN   = 20;
    localparam int TCP_LEN      = 20;
    localparam int UDP_LEN      = 8;

    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    localparam int RESULT_BITS = 157;
    localparam int OUT_BYTES   = (RESULT_BITS + 7) / 8;
    localparam int OUT_BITS    = OUT_BYTES * 8;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_SHORT_ETH     = 3'd1,
        ST_NOT_IPV4      = 3'd2,
        ST_SHORT_IP      = 3'd3,
        ST_SHORT_TCP     = 3'd4,
        ST_SHORT_UDP     = 3'd5,
        ST_SHORT_PAYLOAD = 3'd6
    } status_t;

    // header fields captured while a frame passes
    typedef struct packed {
        logic [15:0] eth_type;
        logic [3:0]  ip_words;
        logic [7:0]  proto;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [3:0]  tcp_words;
        logic        saturated;
    } hdr_state_t;

    // frame summary, last member in the lowest bits
    typedef struct packed {
        logic [15:0] payload_bytes;
        logic [15:0] payload_offset;
        logic [15:0] dport;
        logic [15:0] sport;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
        logic [7:0]  protocol;
        logic        is_ipv4;
        status_t     status;
        logic        length_overflow;
        logic [15:0] frame_bytes;
    } result_t;

endpackage

@@ rtl/eihp_capture.sv @@
// byte counter and positional header field capture
module eihp_capture #(
    parameter int COUNT_BITS = eihp_pkg::COUNT_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output eihp_pkg::hdr_state_t   hdr_next,
    output logic [COUNT_BITS-1:0]  count_next,
    output logic [7:0]             l4_start
);
    import eihp_pkg::*;

    localparam int PW = COUNT_BITS + 8;

    hdr_state_t            hdr_reg;
    logic [COUNT_BITS-1:0] count_reg;

    logic [PW-1:0] p_w;
    logic [PW-1:0] l4_w;
    logic [3:0]    ip_words_n;

    assign p_w        = {8'd0, count_reg};
    assign ip_words_n = (p_w == PW'(IHL_POS)) ? data_byte[3:0] : hdr_reg.ip_words;
    assign l4_start   = 8'(ETH_LEN) + {2'b00, ip_words_n, 2'b00};
    assign l4_w       = {{COUNT_BITS{1'b0}}, l4_start};

    always_comb begin
        hdr_next          = hdr_reg;
        hdr_next.ip_words = ip_words_n;
        if (p_w == PW'(TYPE_POS_HI) || p_w == PW'(TYPE_POS_LO)) begin
            hdr_next.eth_type = {hdr_reg.eth_type[7:0], data_byte};
        end
        if (p_w == PW'(PROTO_POS)) begin
            hdr_next.proto = data_byte;
        end
        if (p_w >= PW'(SRC_FIRST) && p_w <= PW'(SRC_LAST)) begin
            hdr_next.src_addr = {hdr_reg.src_addr[23:0], data_byte};
        end
        if (p_w >= PW'(DST_FIRST) && p_w <= PW'(DST_LAST)) begin
            hdr_next.dst_addr = {hdr_reg.dst_addr[23:0], data_byte};
        end
        // ports sit in the first four bytes after the ip header
        if (p_w >= l4_w && p_w < l4_w + PW'(2)) begin
            hdr_next.sport = {hdr_reg.sport[7:0], data_byte};
        end
        if (p_w >= l4_w + PW'(2) && p_w < l4_w + PW'(4)) begin
            hdr_next.dport = {hdr_reg.dport[7:0], data_byte};
        end
        if (p_w == l4_w + PW'(TCP_OFF_POS)) begin
            hdr_next.tcp_words = data_byte[7:4];
        end
        // counter holds at all ones and flags it
        if (count_reg == {COUNT_BITS{1'b1}}) begin
            hdr_next.saturated = 1'b1;
            count_next         = count_reg;
        end else begin
            count_next         = count_reg + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg   <= '0;
            count_reg <= '0;
        end else if (step) begin
            if (last_byte) begin
                hdr_reg   <= '0;
                count_reg <= '0;
            end else begin
                hdr_reg   <= hdr_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

@@ rtl/eihp_summary.sv @@
// frame summary: length checks per layer, payload offset and length
module eihp_summary #(
    parameter int COUNT_BITS = eihp_pkg::COUNT_BITS_DEF
) (
    input  eihp_pkg::hdr_state_t   hdr,
    input  logic [COUNT_BITS-1:0]  frame_count,
    input  logic [7:0]             l4_start,
    output eihp_pkg::result_t      result
);
    import eihp_pkg::*;

    localparam int PW = COUNT_BITS + 8;

    logic [PW-1:0] len_w;
    logic [PW-1:0] l4_w;
    logic [7:0]    poff;
    logic [PW-1:0] poff_w;
    logic [PW-1:0] plen_w;
    logic          is_tcp;
    logic          is_udp;

    assign len_w  = {8'd0, frame_count};
    assign l4_w   = {{COUNT_BITS{1'b0}}, l4_start};
    assign is_tcp = (hdr.proto == PROTO_TCP);
    assign is_udp = (hdr.proto == PROTO_UDP);

    always_comb begin
        priority if (is_tcp) begin
            poff = l4_start + {2'b00, hdr.tcp_words, 2'b00};
        end else if (is_udp) begin
            poff = l4_start + 8'(UDP_LEN);
        end else begin
            poff = l4_start;
        end
    end

    assign poff_w = {{COUNT_BITS{1'b0}}, poff};
    assign plen_w = len_w - poff_w;

    always_comb begin
        result                 = '0;
        result.frame_bytes     = len_w[15:0];
        result.length_overflow = hdr.saturated;
        result.status          = ST_OK;
        priority if (len_w < PW'(ETH_LEN)) begin
            result.status = ST_SHORT_ETH;
        end else if (hdr.eth_type != TYPE_IPV4) begin
            result.status = ST_NOT_IPV4;
        end else begin
            result.is_ipv4 = 1'b1;
            priority if (len_w < PW'(ETH_LEN + IP_MIN_LEN)) begin
                result.status = ST_SHORT_IP;
            end else begin
                result.protocol = hdr.proto;
                result.src_addr = hdr.src_addr;
                result.dst_addr = hdr.dst_addr;
                priority if (is_tcp && len_w < l4_w + PW'(TCP_LEN)) begin
                    result.status = ST_SHORT_TCP;
                end else if (is_udp && len_w < l4_w + PW'(UDP_LEN)) begin
                    result.status = ST_SHORT_UDP;
                end else begin
                    result.payload_offset = {8'd0, poff};
                    if (is_tcp || is_udp) begin
                        result.sport = hdr.sport;
                        result.dport = hdr.dport;
                    end
                    if (len_w < poff_w) begin
                        result.status = ST_SHORT_PAYLOAD;
                    end else begin
                        result.payload_bytes = plen_w[15:0];
                    end
                end
            end
        end
    end

endmodule

@@ rtl/eth_ipv4_l4_header_parser.sv @@
// top level of the ethernet / ipv4 / tcp / udp header parser
// throughput: one frame byte per cycle while not stalled, back to back, frames may follow without a gap
// the summary of a frame passes the input register, then the result register, to m_axis_tvalid
// the only stall is a last beat meeting a held summary that has not been taken
// reset: synchronous, aresetn low clears the counter, the captures and both valid flags
module eth_ipv4_l4_header_parser #(
    parameter int COUNT_BITS = eihp_pkg::COUNT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream, one frame byte per beat
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // data_byte [7:0]
    input  logic                          s_axis_tlast,  // last_byte
    // summary stream, one beat per frame
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // frame_bytes [15:0], length_overflow [16], status [19:17], is_ipv4 [20],
    // protocol [28:21], src_addr [60:29], dst_addr [92:61], sport [108:93],
    // dport [124:109], payload_offset [140:125], payload_bytes [156:141],
    // zero pad [159:157]
    output logic [eihp_pkg::OUT_BITS-1:0] m_axis_tdata
);
    import eihp_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // result register
    logic       out_valid_reg;
    result_t    out_data_reg;

    hdr_state_t            hdr_next;
    logic [COUNT_BITS-1:0] count_next;
    logic [7:0]            l4_start;
    result_t               result;
    logic                  step;

    // a held byte moves on unless it is a last beat and the summary slot is full and not being taken
    assign step          = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // running count and header captures, cleared after the last beat
    eihp_capture #(
        .COUNT_BITS (COUNT_BITS)
    ) u_capture (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .data_byte  (in_byte_reg),
        .last_byte  (in_last_reg),
        .hdr_next   (hdr_next),
        .count_next (count_next),
        .l4_start   (l4_start)
    );

    // summary worked out from the state as it stands after the last byte
    eihp_summary #(
        .COUNT_BITS (COUNT_BITS)
    ) u_summary (
        .hdr         (hdr_next),
        .frame_count (count_next),
        .l4_start    (l4_start),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && in_last_reg) begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_BITS - RESULT_BITS)'(0), out_data_reg};

endmodule

@@ tb/sv/eihp_summary_checker.sv @@
// predicts and checks the frame summaries of the header parser from the beats on both channels
module eihp_summary_checker #(
    parameter int COUNT_BITS = eihp_pkg::COUNT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,
    input  logic                          s_axis_tlast,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [eihp_pkg::OUT_BITS-1:0] m_axis_tdata,
    output int                            mismatches,
    output int                            pending,
    output int                            beats_taken,
    output int                            summaries_checked,
    output logic [6:0]                    status_seen,
    output int                            overflow_frames
);
    timeunit 1ns;
    timeprecision 1ps;
    import eihp_pkg::*;

    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

    // running captures of the frame in flight
    longint unsigned byte_count;
    logic [15:0]     eth_type_acc;
    logic [3:0]      ihl_acc;
    logic [7:0]      proto_acc;
    logic [31:0]     src_acc;
    logic [31:0]     dst_acc;
    logic [15:0]     sport_acc;
    logic [15:0]     dport_acc;
    logic [3:0]      doff_acc;
    logic            sat_acc;

    result_t    summary_q[$];
    int         err_cnt = 0;
    int         beat_cnt = 0;
    int         checked_cnt = 0;
    int         ovf_cnt = 0;
    logic [6:0] seen_mask = '0;

    task automatic clear_capture();
        byte_count   = 0;
        eth_type_acc = '0;
        ihl_acc      = '0;
        proto_acc    = '0;
        src_acc      = '0;
        dst_acc      = '0;
        sport_acc    = '0;
        dport_acc    = '0;
        doff_acc     = '0;
        sat_acc      = 1'b0;
    endtask

    // one frame byte in, one summary queued when it closes the frame
    task automatic absorb_byte(input logic [7:0] b, input logic lst);
        longint unsigned pos;
        longint unsigned l4;
        longint unsigned len;
        longint unsigned poff;
        result_t         r;
        pos = byte_count;
        if (pos == IHL_POS) ihl_acc = b[3:0];
        if (pos == TYPE_POS_HI || pos == TYPE_POS_LO) eth_type_acc = {eth_type_acc[7:0], b};
        if (pos == PROTO_POS) proto_acc = b;
        if (pos >= SRC_FIRST && pos <= SRC_LAST) src_acc = {src_acc[23:0], b};
        if (pos >= DST_FIRST && pos <= DST_LAST) dst_acc = {dst_acc[23:0], b};
        // transport header position follows the length nibble, even a short one
        l4 = ETH_LEN + 4 * 64'(ihl_acc);
        if (pos >= l4 && pos < l4 + 2) sport_acc = {sport_acc[7:0], b};
        if (pos >= l4 + 2 && pos < l4 + 4) dport_acc = {dport_acc[7:0], b};
        if (pos == l4 + TCP_OFF_POS) doff_acc = b[7:4];
        if (pos >= COUNT_MAX) begin
            sat_acc = 1'b1;
        end else begin
            byte_count = pos + 1;
        end
        if (!lst) return;

        len = byte_count;
        r = '0;
        r.status = ST_OK;
        r.frame_bytes = len[15:0];
        r.length_overflow = sat_acc;
        if (len < ETH_LEN) begin
            r.status = ST_SHORT_ETH;
        end else if (eth_type_acc != TYPE_IPV4) begin
            r.status = ST_NOT_IPV4;
        end else begin
            r.is_ipv4 = 1'b1;
            if (len < ETH_LEN + IP_MIN_LEN) begin
                r.status = ST_SHORT_IP;
            end else begin
                r.protocol = proto_acc;
                r.src_addr = src_acc;
                r.dst_addr = dst_acc;
                if (proto_acc == PROTO_TCP && len < l4 + TCP_LEN) begin
                    r.status = ST_SHORT_TCP;
                end else if (proto_acc == PROTO_UDP && len < l4 + UDP_LEN) begin
                    r.status = ST_SHORT_UDP;
                end else begin
                    if (proto_acc == PROTO_TCP) begin
                        poff = l4 + 4 * 64'(doff_acc);
                        r.sport = sport_acc;
                        r.dport = dport_acc;
                    end else if (proto_acc == PROTO_UDP) begin
                        poff = l4 + UDP_LEN;
                        r.sport = sport_acc;
                        r.dport = dport_acc;
                    end else begin
                        // other protocols: payload straight after the ip header
                        poff = l4;
                    end
                    r.payload_offset = poff[15:0];
                    if (len < poff) begin
                        r.status = ST_SHORT_PAYLOAD;
                    end else begin
                        r.payload_bytes = 16'(len - poff);
                    end
                end
            end
        end
        summary_q.push_back(r);
        clear_capture();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want) begin
            err_cnt++;
            $display("%0t ns  %s mismatch: expected %0h, got %0h", $time, name, want, seen);
        end
    endtask

    task automatic compare_summary(input logic [OUT_BITS-1:0] beat);
        result_t seen;
        result_t want;
        seen = beat[RESULT_BITS-1:0];
        if (summary_q.size() == 0) begin
            err_cnt++;
            $display("%0t ns  summary beat with nothing expected: %h", $time, beat);
            return;
        end
        want = summary_q.pop_front();
        check_field("frame_bytes",     32'(want.frame_bytes),     32'(seen.frame_bytes));
        check_field("length_overflow", 32'(want.length_overflow), 32'(seen.length_overflow));
        check_field("status",          32'(want.status),          32'(seen.status));
        check_field("is_ipv4",         32'(want.is_ipv4),         32'(seen.is_ipv4));
        check_field("protocol",        32'(want.protocol),        32'(seen.protocol));
        check_field("src_addr",        want.src_addr,             seen.src_addr);
        check_field("dst_addr",        want.dst_addr,             seen.dst_addr);
        check_field("sport",           32'(want.sport),           32'(seen.sport));
        check_field("dport",           32'(want.dport),           32'(seen.dport));
        check_field("payload_offset",  32'(want.payload_offset),  32'(seen.payload_offset));
        check_field("payload_bytes",   32'(want.payload_bytes),   32'(seen.payload_bytes));
        checked_cnt++;
        seen_mask[want.status] = 1'b1;
        if (want.length_overflow) ovf_cnt++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_capture();
        end else begin
            if (m_axis_tvalid && m_axis_tready) compare_summary(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) begin
                beat_cnt++;
                absorb_byte(s_axis_tdata, s_axis_tlast);
            end
        end
        mismatches        <= err_cnt;
        pending           <= summary_q.size();
        beats_taken       <= beat_cnt;
        summaries_checked <= checked_cnt;
        status_seen       <= seen_mask;
        overflow_frames   <= ovf_cnt;
    end

endmodule

@@ tb/sv/tb_eth_ipv4_l4_header_parser.sv @@
// top of the header parser testbench: clock, reset, frame stimulus and verdict
module tb_eth_ipv4_l4_header_parser;
    timeunit 1ns;
    timeprecision 1ps;
    import eihp_pkg::*;

    localparam int          COUNT_BITS       = COUNT_BITS_DEF;
    localparam int          CYCLE_LIMIT      = 1_000_000;
    localparam int          RESET_CYCLES     = 11;
    localparam int          DRAIN_CYCLES     = 10;
    localparam int          BYTES_PER_PHASE  = 40;
    localparam int          FRAMES_PER_PHASE = 2;
    localparam int          FILL_RANDOM      = -1;
    localparam logic [15:0] TYPE_IPV6        = 16'h86DD;
    localparam logic [7:0]  PROTO_ICMP       = 8'd1;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata  = '0;
    logic                s_axis_tlast  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] m_axis_tdata;

    // checker outputs
    int         mismatches;
    int         pending;
    int         beats_taken;
    int         summaries_checked;
    logic [6:0] status_seen;
    int         overflow_frames;

    // idling knobs, percent of cycles
    int idle_pct  = 0;
    int stall_pct = 0;

    int cycle_cnt   = 0;
    int frames_sent = 0;
    int bytes_sent  = 0;

    always #2 aclk = ~aclk;

    eth_ipv4_l4_header_parser #(
        .COUNT_BITS(COUNT_BITS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    eihp_summary_checker #(
        .COUNT_BITS(COUNT_BITS)
    ) checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .s_axis_tlast      (s_axis_tlast),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .mismatches        (mismatches),
        .pending           (pending),
        .beats_taken       (beats_taken),
        .summaries_checked (summaries_checked),
        .status_seen       (status_seen),
        .overflow_frames   (overflow_frames)
    );

    // watchdog against a hung handshake or a summary that never comes
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d summaries outstanding", cycle_cnt, pending);
            $display("** eth_ipv4_l4_header_parser: FAILED **");
            $finish;
        end
    end

    // summary side back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // one byte beat; idle cycles carry junk data with tvalid low
    task automatic send_beat(input logic [7:0] d, input logic lst);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tlast  <= 1'($urandom);
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= lst;
        @(posedge aclk);
        // tready read here is the value that was seen at this edge
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // build a frame of the given length and stream it; header fields are
    // placed by position, only where the frame is long enough to hold them
    task automatic send_frame(input logic [15:0] etype, input logic [3:0] ihl,
                              input logic [7:0] proto, input logic [3:0] doff,
                              input int total, input int fill);
        logic [7:0] frame_buf[$];
        int         l4;
        int         i;
        l4 = ETH_LEN + 4 * int'(ihl);
        for (i = 0; i < total; i++) begin
            frame_buf.push_back(fill == FILL_RANDOM ? 8'($urandom) : 8'(fill));
        end
        if (total > TYPE_POS_LO) begin
            frame_buf[TYPE_POS_HI] = etype[15:8];
            frame_buf[TYPE_POS_LO] = etype[7:0];
        end
        if (total > IHL_POS) frame_buf[IHL_POS] = {4'h4, ihl};
        if (total > PROTO_POS) frame_buf[PROTO_POS] = proto;
        if (total > l4 + TCP_OFF_POS) begin
            frame_buf[l4 + TCP_OFF_POS] = {doff, frame_buf[l4 + TCP_OFF_POS][3:0]};
        end
        for (i = 0; i < total; i++) begin
            send_beat(frame_buf[i], i == total - 1);
        end
        frames_sent++;
        bytes_sent += total;
    endtask

    // mostly well formed ipv4 tcp / udp frames, some truncated, some foreign
    task automatic random_frame();
        logic [15:0] etype;
        logic [3:0]  ihl;
        logic [3:0]  doff;
        logic [7:0]  proto;
        int          pick;
        int          hdr;
        int          full;
        int          total;
        etype = ($urandom_range(9) != 0) ? TYPE_IPV4 : 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 80) ihl = 4'd5;
        else if (pick < 95) ihl = 4'($urandom_range(15, 6));
        else ihl = 4'($urandom_range(4, 0));
        pick = $urandom_range(99);
        if (pick < 40) proto = PROTO_TCP;
        else if (pick < 80) proto = PROTO_UDP;
        else proto = 8'($urandom);
        doff = ($urandom_range(9) < 8) ? 4'($urandom_range(8, 5)) : 4'($urandom);
        if (proto == PROTO_TCP) hdr = (doff > 5) ? 4 * int'(doff) : TCP_LEN;
        else if (proto == PROTO_UDP) hdr = UDP_LEN;
        else hdr = 0;
        full = ETH_LEN + 4 * int'(ihl) + hdr + $urandom_range(16);
        // a share of frames get a random length, from a single byte up to four bytes past the full length
        total = ($urandom_range(9) < 7) ? full : $urandom_range(full + 4, 1);
        send_frame(etype, ihl, proto, doff, total, FILL_RANDOM);
    endtask

    initial begin
        int phase;
        int start_bytes;
        int start_frames;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames, back to back with no idling
        // frame shorter than the ethernet header, single byte and one short
        send_frame(TYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 1, 0);
        send_frame(TYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 13, 8'hFF);
        // ipv4 frame with only the ethernet header, and one byte short of ip
        send_frame(TYPE_IPV4, 4'd5, PROTO_UDP, 4'd5, 14, FILL_RANDOM);
        send_frame(TYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 33, FILL_RANDOM);
        // non ipv4 types, including all zero and all one frames
        send_frame(TYPE_IPV6, 4'd5, PROTO_UDP, 4'd5, 24, FILL_RANDOM);
        send_frame(16'h0000, 4'd0, 8'h00, 4'd0, 24, 0);
        send_frame(16'hFFFF, 4'hF, 8'hFF, 4'hF, 24, 8'hFF);
        // transport header cut short
        send_frame(TYPE_IPV4, 4'd5, PROTO_UDP, 4'd5, 41, FILL_RANDOM);
        send_frame(TYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 53, FILL_RANDOM);
        // payload exactly at frame end for tcp and udp
        send_frame(TYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 54, FILL_RANDOM);
        send_frame(TYPE_IPV4, 4'd5, PROTO_UDP, 4'd5, 42, FILL_RANDOM);
        // largest tcp data offset past the frame end, then a normal payload
        send_frame(TYPE_IPV4, 4'd5, PROTO_TCP, 4'hF, 60, FILL_RANDOM);
        send_frame(TYPE_IPV4, 4'd5, PROTO_TCP, 4'd8, 72, FILL_RANDOM);
        // longest ip header with all ones addresses and ports
        send_frame(TYPE_IPV4, 4'hF, PROTO_UDP, 4'd5, 90, 8'hFF);
        // other protocols: payload right after the ip header
        send_frame(TYPE_IPV4, 4'd5, PROTO_ICMP, 4'd0, 34, FILL_RANDOM);
        send_frame(TYPE_IPV4, 4'hF, 8'hFF, 4'd0, 60, FILL_RANDOM);
        send_frame(TYPE_IPV4, 4'd5, 8'h00, 4'd0, 40, 0);
        // ip length nibble below five, transport fields overlap the ip header
        send_frame(TYPE_IPV4, 4'd0, PROTO_TCP, 4'd5, 40, FILL_RANDOM);
        send_frame(TYPE_IPV4, 4'd2, PROTO_UDP, 4'd0, 34, FILL_RANDOM);
        send_frame(TYPE_IPV4, 4'd4, PROTO_TCP, 4'd0, 40, FILL_RANDOM);
        send_frame(TYPE_IPV4, 4'd1, PROTO_TCP, 4'hF, 34, FILL_RANDOM);

        // random frames under each idling pattern in turn
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct = 87;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 87;
                end
                default: begin
                    idle_pct = 11;
                    stall_pct = 11;
                end
            endcase
            start_bytes = bytes_sent;
            start_frames = frames_sent;
            while (bytes_sent - start_bytes < BYTES_PER_PHASE ||
                   frames_sent - start_frames < FRAMES_PER_PHASE) begin
                random_frame();
            end
        end
        s_axis_tvalid <= 1'b0;

        // let the checker count the last summary before draining
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d frames of %0d bytes, %0d beats taken, %0d summaries checked",
                 frames_sent, bytes_sent, beats_taken, summaries_checked);
        $display("status codes met (one bit per code) %07b, saturated frames %0d",
                 status_seen, overflow_frames);
        if (mismatches == 0) begin
            $display("** eth_ipv4_l4_header_parser: PASSED **");
        end else begin
            $display("** eth_ipv4_l4_header_parser: FAILED **");
        end
        $finish;
    end

endmodule
